>>> rtl/core/bfcs_pkg.sv
package bfcs_pkg;

  localparam int REQ_W   = 7;
  localparam int START_W = 6;
  localparam int LEN_W   = 7;

  // One search result, found in the lowest bit.
  typedef struct packed {
    logic [LEN_W-1:0]   run_length;
    logic [START_W-1:0] start_slot;
    logic               found;
  } result_t;

endpackage

>>> rtl/core/bfcs_front.sv
module bfcs_front #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [63:0]                   free_mask,
  input  logic [bfcs_pkg::REQ_W-1:0]    required_slots,
  input  logic                          last_link,
  output logic                          push,
  input  logic                          push_ready,
  output logic [SLOT_COUNT+bfcs_pkg::REQ_W-1:0] push_data
);
  import bfcs_pkg::*;

  logic [SLOT_COUNT-1:0] common_mask;
  logic [SLOT_COUNT-1:0] merged;
  logic                  accept;

  assign merged    = common_mask & free_mask[SLOT_COUNT-1:0];
  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;
  assign push      = accept && last_link;
  assign push_data = {required_slots, merged};

  always_ff @(posedge clk) begin
    if (rst) begin
      common_mask <= '1;
    end else if (accept) begin
      if (last_link) begin
        common_mask <= '1;
      end else begin
        common_mask <= merged;
      end
    end
  end

endmodule

>>> rtl/core/bfcs_queue.sv
module bfcs_queue #(
  parameter int WIDTH = 71
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/bfcs_back.sv
module bfcs_back #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  job_valid,
  output logic                                  job_pop,
  input  logic [SLOT_COUNT+bfcs_pkg::REQ_W-1:0] job_data,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output bfcs_pkg::result_t                     res
);
  import bfcs_pkg::*;

  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t                state;
  logic [SLOT_COUNT-1:0] mask_sh;
  logic [REQ_W-1:0]      need;
  logic [CW-1:0]         slot;
  logic [CW-1:0]         run;
  logic                  have;
  logic [CW-1:0]         best_len;
  logic [CW-1:0]         best_start;

  logic                  free_here;
  logic                  take_run;

  // A run closes on an occupied slot; a zero requirement acts as one because
  // an empty run never qualifies.
  assign free_here = mask_sh[0];
  assign take_run  = !free_here && (run != '0) && (REQ_W'(run) >= need) &&
                     (!have || (run < best_len));
  assign job_pop   = (state == IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_valid <= 1'b0;
    end else begin
      // In DONE the output register is either reloaded or still waiting, so
      // the valid flag is only cleared outside that state.
      if (res_valid && res_ready && (state != DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            mask_sh <= job_data[SLOT_COUNT-1:0];
            need    <= job_data[SLOT_COUNT+REQ_W-1:SLOT_COUNT];
            slot    <= '0;
            run     <= '0;
            have    <= 1'b0;
            state   <= SCAN;
          end
        end
        SCAN: begin
          // Zeros shift in, so the step past the last slot sees it occupied.
          mask_sh <= mask_sh >> 1;
          if (free_here) begin
            run <= run + CW'(1);
          end else begin
            run <= '0;
          end
          if (take_run) begin
            have       <= 1'b1;
            best_len   <= run;
            best_start <= slot - run;
          end
          slot <= slot + CW'(1);
          if (slot == CW'(SLOT_COUNT)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!res_valid || res_ready) begin
            res_valid      <= 1'b1;
            res.found      <= have;
            res.start_slot <= have ? START_W'(best_start) : '0;
            res.run_length <= have ? LEN_W'(best_len) : '0;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/best_fit_contiguous_slot_finder.sv
// Best-fit contiguous slot finder. Each input beat carries one link's
// free-slot mask, which is ANDed into a running mask of slots free on every
// link of the path so far; the beat with tlast set ends the path and also
// carries the number of contiguous slots the request needs. For that path the
// block finds every maximal free run of at least that length among slots
// 0 to SLOT_COUNT-1 and returns the shortest one, the lowest start winning a
// tie, as one output beat with found, start_slot and run_length (all zero
// when nothing fits). A required count of zero is treated as one. Link beats
// are taken one per cycle by the front end while the queue has room; closed
// paths wait in a two-entry queue while the back end scans one slot per
// cycle, each path going through a load step, a scan of every slot and one
// step past the last, and a hand-off to the output register. The input
// stalls on any beat only when the queue already holds two closed paths.
module best_fit_contiguous_slot_finder #(
  parameter int SLOT_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // free_mask[63:0], required_slots[70:64], zero[71]
  input  logic        s_tlast,  // last_link
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // found[0], start_slot[6:1], run_length[13:7], zero[15:14]
);
  import bfcs_pkg::*;

  localparam int JOB_W = SLOT_COUNT + REQ_W;

  logic             push;
  logic             push_ready;
  logic [JOB_W-1:0] push_data;
  logic             job_valid;
  logic             job_pop;
  logic [JOB_W-1:0] job_data;
  result_t          res;

  // Front end: merges link masks and closes a path on tlast.
  bfcs_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .free_mask     (s_tdata[63:0]),
    .required_slots(s_tdata[70:64]),
    .last_link     (s_tlast),
    .push          (push),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // Queue of closed paths: combined mask plus the required count.
  bfcs_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop       (job_pop),
    .pop_valid (job_valid),
    .pop_data  (job_data)
  );

  // Back end: serial best-fit scan and the output register.
  bfcs_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job_pop  (job_pop),
    .job_data (job_data),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  assign m_tdata = {2'b00, res};

endmodule
